// File: src/lrupr_pkg.sv
// shared constants for the lru page replacement core
package lrupr_pkg;

   localparam int FRAMES_DEFAULT    = 8;
   localparam int PAGE_BITS_DEFAULT = 16;

   // configuration register file
   localparam int CSR_AW            = 3;
   localparam int CSR_DW            = 32;
   localparam int FIU_W             = 4;
   localparam logic [FIU_W-1:0] FIU_RESET = 4'd3;
   localparam int REG_FRAMES_IN_USE = 0;

   // result field widths
   localparam int FRAME_OUT_W = 3;
   localparam int EVICT_W     = 16;
   localparam int FAULT_W     = 32;

endpackage

// File: src/lrupr_ram.sv
// generic simple dual port ram with registered read
module lrupr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lrupr_csr.sv
// apb register file holding the managed frame count
module lrupr_csr
   import lrupr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic [FIU_W-1:0]  frames_in_use
);

   logic [FIU_W-1:0] frames_in_use_ff;
   logic [FIU_W-1:0] frames_in_use_in;
   logic             sel_fiu;

   assign sel_fiu = (paddr[CSR_AW-1:2] == (CSR_AW-2)'(REG_FRAMES_IN_USE));

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (psel && penable && pwrite && sel_fiu) begin
         frames_in_use_in = pwdata[FIU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FIU_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   assign prdata        = sel_fiu ? CSR_DW'(frames_in_use_ff) : '0;
   assign pready        = 1'b1;
   assign frames_in_use = frames_in_use_ff;

endmodule

// File: src/lrupr_rank.sv
// per-frame valid bits and recency ranks with parallel touch update
module lrupr_rank #(
   parameter int FRAMES = 8,
   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int RANK_W = IDX_W,
   localparam int CNT_W  = $clog2(FRAMES + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [CNT_W-1:0]               frames_eff,
   input  logic                           touch_en,
   input  logic [IDX_W-1:0]               touch_slot,
   input  logic                           touch_miss,
   output logic [FRAMES-1:0]              frame_valid,
   output logic [FRAMES-1:0][RANK_W-1:0]  frame_rank
);

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

   logic [FRAMES-1:0]             valid_ff;
   logic [FRAMES-1:0]             valid_in;
   logic [FRAMES-1:0][RANK_W-1:0] rank_ff;
   logic [FRAMES-1:0][RANK_W-1:0] rank_in;
   logic [RANK_W-1:0]             prior;

   assign prior = rank_ff[touch_slot];

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (touch_en) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (IDX_W'(i) == touch_slot) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end else if (i < int'(frames_eff) && valid_ff[i] && rank_ff[i] < RANK_MAX &&
                         (touch_miss || rank_ff[i] < prior)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   assign frame_valid = valid_ff;
   assign frame_rank  = rank_ff;

endmodule

// File: src/lru_page_replacement_core.sv
// lru page replacement core: frame scan sequencer over the page ram
// a reference scans the page ram one read per cycle, stopping at the matching frame
// on a hit and covering all m managed frames on a miss; an update state then updates
// ranks and writes the page on a miss, waiting while a stalled result is still held
// the result sits in an output register, so the next reference is taken meanwhile
// synchronous reset empties all frames, zeroes ranks and fault count, frame count 3
module lru_page_replacement_core
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PAGE_BITS-1:0]   req_page,
   input  logic                   req_last_reference,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [FRAME_OUT_W-1:0] rsp_frame_index,
   output logic                   rsp_evicted_valid,
   output logic [EVICT_W-1:0]     rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_count,
   output logic                   rsp_final_result,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_AW-1:0]      paddr,
   input  logic [CSR_DW-1:0]      pwdata,
   output logic [CSR_DW-1:0]      prdata,
   output logic                   pready
);

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(FRAMES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [PAGE_BITS-1:0]      page_ff, page_in;
   logic                      last_ff, last_in;
   logic [CNT_W-1:0]          m_ff, m_in;
   logic [CNT_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;
   logic [RANK_W-1:0]         best_ff, best_in;
   logic [IDX_W-1:0]          vict_ff, vict_in;
   logic [PAGE_BITS-1:0]      vict_page_ff, vict_page_in;
   logic [CNT_W-1:0]          filled_ff, filled_in;
   logic [FAULT_W-1:0]        faults_ff, faults_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [FRAME_OUT_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                      rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [EVICT_W-1:0]        rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_W-1:0]        rsp_faults_ff, rsp_faults_in;
   logic                      rsp_final_ff, rsp_final_in;

   logic [FIU_W-1:0]          frames_in_use;
   logic [CNT_W-1:0]          m_eff;
   logic                      accept;
   logic                      rd_en;
   logic [PAGE_BITS-1:0]      rd_data;
   logic                      wr_en;
   logic [IDX_W-1:0]          upd_slot;
   logic                      upd_go;
   logic                      fill_free;
   logic [FRAMES-1:0]         frame_valid;
   logic [FRAMES-1:0][RANK_W-1:0] frame_rank;
   logic [IDX_W+FRAME_OUT_W-1:0]  slot_ext;
   logic [PAGE_BITS+EVICT_W-1:0]  vict_page_ext;

   lrupr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .frames_in_use (frames_in_use)
   );

   // zero acts as one, anything above the frame count clips to it
   always_comb begin
      if (frames_in_use == '0) begin
         m_eff = CNT_W'(1);
      end else if (int'(frames_in_use) > FRAMES) begin
         m_eff = CNT_W'(FRAMES);
      end else begin
         m_eff = CNT_W'(frames_in_use);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN) && (scan_idx_ff < m_ff);
   assign upd_go    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign fill_free = (filled_ff < m_ff);
   assign upd_slot  = found_ff ? slot_ff : (fill_free ? filled_ff[IDX_W-1:0] : vict_ff);
   assign wr_en     = upd_go && !found_ff;
   assign slot_ext      = (IDX_W+FRAME_OUT_W)'(upd_slot);
   assign vict_page_ext = (PAGE_BITS+EVICT_W)'(vict_page_ff);

   lrupr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (upd_slot),
      .wr_data (page_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   lrupr_rank #(
      .FRAMES (FRAMES)
   ) u_rank (
      .clock       (clock),
      .reset       (reset),
      .frames_eff  (m_ff),
      .touch_en    (upd_go),
      .touch_slot  (upd_slot),
      .touch_miss  (!found_ff),
      .frame_valid (frame_valid),
      .frame_rank  (frame_rank)
   );

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = rd_en;
      cmp_idx_in   = scan_idx_ff[IDX_W-1:0];
      found_in     = found_ff;
      slot_in      = slot_ff;
      best_in      = best_ff;
      vict_in      = vict_ff;
      vict_page_in = vict_page_ff;
      filled_in    = filled_ff;
      faults_in    = faults_ff;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_faults_in   = rsp_faults_ff;
      rsp_final_in    = rsp_final_ff;

      if (rd_en) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            cmp_vld_in = 1'b0;
            if (accept) begin
               page_in     = req_page;
               last_in     = req_last_reference;
               m_in        = m_eff;
               scan_idx_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // compare follows the registered ram read, tracked by cmp_vld and cmp_idx
            if (cmp_vld_ff) begin
               if (frame_valid[cmp_idx_ff] && rd_data == page_ff) begin
                  found_in = 1'b1;
                  slot_in  = cmp_idx_ff;
                  state_in = ST_UPDATE;
               end else begin
                  if (cmp_idx_ff == '0 || frame_rank[cmp_idx_ff] > best_ff) begin
                     best_in      = frame_rank[cmp_idx_ff];
                     vict_in      = cmp_idx_ff;
                     vict_page_in = rd_data;
                  end
                  if (CNT_W'(cmp_idx_ff) == m_ff - 1'b1) begin
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_UPDATE: begin
            if (upd_go) begin
               if (!found_ff) begin
                  if (faults_ff != '1) begin
                     faults_in = faults_ff + 1'b1;
                  end
                  if (fill_free) begin
                     filled_in = filled_ff + 1'b1;
                  end
               end
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = found_ff;
               rsp_frame_in    = slot_ext[FRAME_OUT_W-1:0];
               rsp_ev_valid_in = !found_ff && !fill_free && frame_valid[vict_ff];
               rsp_ev_page_in  = (!found_ff && !fill_free && frame_valid[vict_ff]) ?
                                 vict_page_ext[EVICT_W-1:0] : '0;
               rsp_faults_in   = (!found_ff && faults_ff != '1) ? faults_ff + 1'b1 : faults_ff;
               rsp_final_in    = last_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         filled_ff    <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         filled_ff    <= filled_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      last_ff         <= last_in;
      m_ff            <= m_in;
      scan_idx_ff     <= scan_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      found_ff        <= found_in;
      slot_ff         <= slot_in;
      best_ff         <= best_in;
      vict_ff         <= vict_in;
      vict_page_ff    <= vict_page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_faults_ff   <= rsp_faults_in;
      rsp_final_ff    <= rsp_final_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_faults_ff;
   assign rsp_final_result  = rsp_final_ff;

endmodule

// File: bench/testbench.sv
// self-checking bench for the lru page replacement core
`timescale 1ns / 1ps

module testbench
   import lrupr_pkg::*;
();

   localparam int FRAMES    = FRAMES_DEFAULT;
   localparam int PAGE_BITS = PAGE_BITS_DEFAULT;
   localparam logic [CSR_AW-1:0] FIU_ADDR = CSR_AW'(4 * REG_FRAMES_IN_USE);
   localparam int N_DIRECTED = 25;
   localparam int N_PHASES   = 10;
   localparam int PHASE_REFS = 75;

   typedef struct packed {
      logic                   hit;
      logic [FRAME_OUT_W-1:0] frame_index;
      logic                   evicted_valid;
      logic [EVICT_W-1:0]     evicted_page;
      logic [FAULT_W-1:0]     fault_count;
      logic                   final_result;
   } ref_outcome_type;

   typedef enum logic { ROW_REF, ROW_CFG } row_kind_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN
   } stall_mode_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [3:0]      cfg_val;
      logic [15:0]     page;
      logic            final_ref;
      logic            typed;
      ref_outcome_type want;
   } stim_row_type;

   // page references after reset with three frames; typed rows are obvious by hand
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REF, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b0}},
      '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2, 1'b0}},
      '{ROW_REF, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2, 1'b0}},
      '{ROW_REF, 4'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 32'd3, 1'b0}},
      '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd3, 1'b0}},
      '{ROW_REF, 4'd0,  16'h8000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd4, 1'b0}},
      '{ROW_REF, 4'd0,  16'h0001, 1'b0, 1'b1, '{1'b0, 3'd2, 1'b1, 16'h1234, 32'd5, 1'b0}},
      '{ROW_REF, 4'd0,  16'h0001, 1'b1, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0000, 32'd5, 1'b1}},
      '{ROW_CFG, 4'd8,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h00FF, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h0F0F, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h5555, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'hAAAA, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h7FFF, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h0002, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b0, '0},
      // shrink to one frame: resident pages above frame 0 are no longer seen
      '{ROW_CFG, 4'd1,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b0, '0},
      '{ROW_CFG, 4'd0,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h1111, 1'b1, 1'b0, '0},
      // above the frame parameter: stale ranks give ties
      '{ROW_CFG, 4'd15, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'hAAAA, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h3333, 1'b0, 1'b0, '0},
      '{ROW_REF, 4'd0,  16'h0F0F, 1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PAGE_BITS-1:0]   req_page = '0;
   logic                   req_last_reference = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_hit;
   logic [FRAME_OUT_W-1:0] rsp_frame_index;
   logic                   rsp_evicted_valid;
   logic [EVICT_W-1:0]     rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_count;
   logic                   rsp_final_result;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_AW-1:0]      paddr = '0;
   logic [CSR_DW-1:0]      pwdata = '0;
   logic [CSR_DW-1:0]      prdata;
   logic                   pready;

   // predictor state
   logic [PAGE_BITS-1:0] fr_page [FRAMES];
   logic                 fr_valid [FRAMES];
   logic [2:0]           fr_rank [FRAMES];
   logic [3:0]           fill_count;
   logic [FAULT_W-1:0]   fault_tally;
   logic [FIU_W-1:0]     frames_setting;

   ref_outcome_type pending_outcomes [$];
   int errors = 0;
   int refs_sent = 0;
   int hits_seen = 0;
   int faults_seen = 0;
   int settings_used = 1;
   int burst_left = 0;
   logic [PAGE_BITS-1:0] page_pool [16];

   always #10 clock = ~clock;

   lru_page_replacement_core #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) dut (.*);

   function automatic int managed_frames();
      if (frames_setting == 0) return 1;
      if (frames_setting > FRAMES) return FRAMES;
      return int'(frames_setting);
   endfunction

   // frame j becomes most recent; valid frames younger than prior age by one
   function automatic void age_ranks(input int j, input int prior);
      int m;
      m = managed_frames();
      for (int i = 0; i < m; i++) begin
         if (i != j && fr_valid[i] && int'(fr_rank[i]) < prior && fr_rank[i] < 3'(FRAMES - 1))
            fr_rank[i]++;
      end
      fr_rank[j] = '0;
   endfunction

   function automatic ref_outcome_type lru_lookup(input logic [PAGE_BITS-1:0] page,
                                                 input logic final_ref);
      ref_outcome_type r;
      int m, slot, best;
      bit found;
      r = '0;
      m = managed_frames();
      slot = 0;
      found = 1'b0;
      for (int i = 0; i < m; i++) begin
         if (!found && fr_valid[i] && fr_page[i] == page) begin
            slot = i;
            found = 1'b1;
         end
      end
      if (found) begin
         age_ranks(slot, int'(fr_rank[slot]));
      end else begin
         if (fault_tally != '1) fault_tally++;
         if (int'(fill_count) < m) begin
            slot = int'(fill_count);
            fill_count++;
         end else begin
            // lowest numbered frame among the oldest
            best = -1;
            for (int i = 0; i < m; i++) begin
               if (int'(fr_rank[i]) > best) begin
                  best = int'(fr_rank[i]);
                  slot = i;
               end
            end
            if (fr_valid[slot]) begin
               r.evicted_valid = 1'b1;
               r.evicted_page = EVICT_W'(fr_page[slot]);
            end
         end
         fr_page[slot] = page;
         fr_valid[slot] = 1'b1;
         age_ranks(slot, FRAMES);
      end
      r.hit = found;
      r.frame_index = FRAME_OUT_W'(slot);
      r.fault_count = fault_tally;
      r.final_result = final_ref;
      return r;
   endfunction

   // present one reference, hold it until taken, then log what it should produce
   task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic final_ref,
                                 input logic typed, input ref_outcome_type want);
      ref_outcome_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_page <= page;
      req_last_reference <= final_ref;
      do @(posedge clock); while (req_stall);
      predicted = lru_lookup(page, final_ref);
      pending_outcomes.push_back(typed ? want : predicted);
      refs_sent++;
      if (predicted.hit) hits_seen++;
      else faults_seen++;
      // bursts of random length with random gaps
      if (burst_left == 0) begin
         repeat (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write_check(input logic [CSR_AW-1:0] addr, input logic [FIU_W-1:0] v);
      logic [CSR_DW-1:0] readback;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= CSR_DW'(v);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      frames_setting = v;
      settings_used++;
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== CSR_DW'(v)) begin
         $error("frames_in_use: expected %0d, actual %0d", v, readback);
         errors++;
      end
   endtask

   // result side stalls on its own pattern, with clean stretches
   initial begin
      stall_mode_type mode;
      logic [7:0] pat;
      int k;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         pat = 8'($urandom);
         k = 0;
         repeat ($urandom_range(8, 80)) begin
            @(negedge clock);
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= pat[k % 8];
            endcase
            k++;
         end
      end
   end

   always @(posedge clock) begin
      ref_outcome_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
         end else begin
            w = pending_outcomes.pop_front();
            if (rsp_hit !== w.hit) begin
               $error("hit: expected %0d, actual %0d", w.hit, rsp_hit);
               errors++;
            end
            if (rsp_frame_index !== w.frame_index) begin
               $error("frame_index: expected %0d, actual %0d", w.frame_index, rsp_frame_index);
               errors++;
            end
            if (rsp_evicted_valid !== w.evicted_valid) begin
               $error("evicted_valid: expected %0d, actual %0d",
                      w.evicted_valid, rsp_evicted_valid);
               errors++;
            end
            if (rsp_evicted_page !== w.evicted_page) begin
               $error("evicted_page: expected %h, actual %h", w.evicted_page, rsp_evicted_page);
               errors++;
            end
            if (rsp_fault_count !== w.fault_count) begin
               $error("fault_count: expected %0d, actual %0d", w.fault_count, rsp_fault_count);
               errors++;
            end
            if (rsp_final_result !== w.final_result) begin
               $error("final_result: expected %0d, actual %0d",
                      w.final_result, rsp_final_result);
               errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      int phase_settings [N_PHASES];
      int top;
      logic [PAGE_BITS-1:0] page;
      phase_settings = '{8, 1, 5, 15, 0, 2, 7, 4, 6, 3};
      for (int i = 0; i < FRAMES; i++) begin
         fr_page[i] = '0;
         fr_valid[i] = 1'b0;
         fr_rank[i] = '0;
      end
      fill_count = '0;
      fault_tally = '0;
      frames_setting = FIU_RESET;
      for (int i = 0; i < 16; i++) page_pool[i] = PAGE_BITS'($urandom);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CFG) begin
            settle();
            csr_write_check(FIU_ADDR, directed_rows[r].cfg_val);
         end else begin
            send_reference(directed_rows[r].page, directed_rows[r].final_ref,
                           directed_rows[r].typed, directed_rows[r].want);
         end
      end

      // random phases: mostly a small working set so hits and evictions both occur
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         csr_write_check(FIU_ADDR, FIU_W'(phase_settings[p]));
         repeat (4) page_pool[$urandom_range(0, 15)] = PAGE_BITS'($urandom);
         top = managed_frames() + 2;
         if (top > 15) top = 15;
         repeat (PHASE_REFS) begin
            if ($urandom_range(0, 99) < 12) page = PAGE_BITS'($urandom);
            else page = page_pool[$urandom_range(0, top)];
            send_reference(page, ($urandom_range(0, 15) == 0), 1'b0, '0);
         end
      end

      settle();
      $display("covered %0d page references: %0d hits, %0d faults", refs_sent, hits_seen,
               faults_seen);
      $display("frame counts 0, 1 and 15 included, %0d settings applied", settings_used);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
